// ===== hw/rtl/attitude_command_framer_crc16_defines.svh =====
// Assertion macros shared by the attitude command framer checkers.
`ifndef ATTITUDE_COMMAND_FRAMER_CRC16_DEFINES_SVH
`define ATTITUDE_COMMAND_FRAMER_CRC16_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define ACF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define ACF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/acf_pkg.sv =====
// Types, frame constants and CRC-16/XMODEM helpers for the attitude command framer.
package acf_pkg;

  typedef logic signed [15:0] angle_t;
  typedef logic [7:0]         byte_t;
  typedef logic [15:0]        crc_t;

  // Frame layout
  localparam int unsigned FrameBytes = 14;
  localparam int unsigned HdrBytes   = 8;
  localparam int unsigned NumStg     = 4;   // one CRC stage per payload byte
  localparam int unsigned CntW       = $clog2(FrameBytes);
  localparam int unsigned StgW       = $clog2(NumStg);

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [StgW-1:0] stg_t;

  localparam cnt_t IdxYawLo   = cnt_t'(8);
  localparam cnt_t IdxYawHi   = cnt_t'(9);
  localparam cnt_t IdxPitchLo = cnt_t'(10);
  localparam cnt_t IdxPitchHi = cnt_t'(11);
  localparam cnt_t IdxCrcLo   = cnt_t'(12);
  localparam cnt_t IdxCrcHi   = cnt_t'(FrameBytes - 1);

  localparam stg_t StgYawLo   = stg_t'(0);
  localparam stg_t StgYawHi   = stg_t'(1);
  localparam stg_t StgPitchLo = stg_t'(2);
  localparam stg_t StgPitchHi = stg_t'(3);

  localparam crc_t CrcPoly = 16'h1021;
  localparam crc_t CrcInit = 16'h0000;

  // Fixed header: sync, control, length, sequence, command
  localparam byte_t HdrTab [HdrBytes] = '{
    8'h55, 8'h66, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0E
  };

  // Fold one byte into the CRC, MSB first
  function automatic crc_t crc_byte(crc_t crc, byte_t data);
    crc_t c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC over the constant header, worked out at elaboration
  function automatic crc_t crc_header();
    crc_t c;
    c = CrcInit;
    for (int i = 0; i < HdrBytes; i++) begin
      c = crc_byte(c, HdrTab[i]);
    end
    return c;
  endfunction

  localparam crc_t CrcHdr = crc_header();

  // Payload byte that a given CRC stage folds in
  function automatic byte_t payload_byte(angle_t yaw, angle_t pitch, stg_t stg);
    byte_t b;
    case (stg)
      StgYawLo:   b = yaw[7:0];
      StgYawHi:   b = yaw[15:8];
      StgPitchLo: b = pitch[7:0];
      StgPitchHi: b = pitch[15:8];
      default:    b = '0;
    endcase
    return b;
  endfunction

  // Frame byte at a given send position
  function automatic byte_t frame_byte_at(cnt_t idx, angle_t yaw, angle_t pitch, crc_t crc);
    byte_t b;
    case (idx)
      IdxYawLo:   b = yaw[7:0];
      IdxYawHi:   b = yaw[15:8];
      IdxPitchLo: b = pitch[7:0];
      IdxPitchHi: b = pitch[15:8];
      IdxCrcLo:   b = crc[7:0];
      IdxCrcHi:   b = crc[15:8];
      default:    b = HdrTab[idx[StgW:0]];
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/acf_cmd_if.sv =====
// Command channel: one yaw and one pitch angle per transfer.
interface acf_cmd_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   yaw_tenths;
  logic signed [15:0]   pitch_tenths;

  modport source (output valid, output yaw_tenths, output pitch_tenths, input ready);
  modport sink   (input valid, input yaw_tenths, input pitch_tenths, output ready);
endinterface

// ===== hw/rtl/acf_frame_if.sv =====
// Frame channel: one frame byte per transfer, last byte flagged.
interface acf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== hw/rtl/attitude_command_framer_crc16.sv =====
// Attitude command framer: yaw/pitch in, 14-byte CRC-16/XMODEM frame out.
//
// Usage:
//   cmd_i   (sink)   takes one yaw and one pitch angle per transfer.
//   frame_o (source) sends the 14 frame bytes in order, frame_last on the
//                    CRC high byte.
// A command enters a four-stage CRC pipeline; each stage folds one payload
// byte into the CRC that was precomputed over the constant 8-byte header.
// The finished frame moves into a byte serializer.
// A command passes through the four CRC stage registers and then the
// serializer register before its first frame byte is valid. The one-byte-wide
// output sets the frame rate; the serializer takes the next frame in the cycle its last byte
// transfers, so frames go out back to back. Up to four further commands
// wait in the pipeline while a frame is sent.
// Stalls: when frame_o.ready is low the current byte holds and the pipeline
// fills; cmd_i.ready drops only once every stage is occupied.
// Reset clears all valid bits and the byte counter; no frame is in flight.
module attitude_command_framer_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  acf_cmd_if.sink     cmd_i,
  acf_frame_if.source frame_o
);
  import acf_pkg::*;

  logic   stg_vld_q   [NumStg];
  angle_t stg_yaw_q   [NumStg];
  angle_t stg_pitch_q [NumStg];
  crc_t   stg_crc_q   [NumStg];

  logic   src_vld     [NumStg];
  angle_t src_yaw     [NumStg];
  angle_t src_pitch   [NumStg];
  crc_t   src_crc     [NumStg];
  crc_t   stg_crc_d   [NumStg];
  logic   stg_rdy     [NumStg+1];

  logic   ser_vld_q;
  angle_t ser_yaw_q;
  angle_t ser_pitch_q;
  crc_t   ser_crc_q;
  cnt_t   ser_cnt_q;
  logic   ser_rdy;
  logic   ser_last;

  // Serializer is free when empty or when its last byte transfers now
  assign ser_last = (ser_cnt_q == IdxCrcHi);
  assign ser_rdy  = !ser_vld_q || (frame_o.ready && ser_last);

  // Backpressure: a stage advances when empty or when the next one advances
  always_comb begin
    stg_rdy[NumStg] = ser_rdy;
    for (int s = NumStg - 1; s >= 0; s--) begin
      stg_rdy[s] = !stg_vld_q[s] || stg_rdy[s+1];
    end
  end

  assign cmd_i.ready = stg_rdy[0];

  // Stage inputs and CRC update, one payload byte per stage
  always_comb begin
    for (int s = 0; s < NumStg; s++) begin
      if (s == 0) begin
        src_vld[s]   = cmd_i.valid;
        src_yaw[s]   = cmd_i.yaw_tenths;
        src_pitch[s] = cmd_i.pitch_tenths;
        src_crc[s]   = CrcHdr;
      end else begin
        src_vld[s]   = stg_vld_q[s-1];
        src_yaw[s]   = stg_yaw_q[s-1];
        src_pitch[s] = stg_pitch_q[s-1];
        src_crc[s]   = stg_crc_q[s-1];
      end
      stg_crc_d[s] = crc_byte(src_crc[s], payload_byte(src_yaw[s], src_pitch[s], stg_t'(s)));
    end
  end

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStg; s++) stg_vld_q[s] <= 1'b0;
    end else begin
      for (int s = 0; s < NumStg; s++) begin
        if (stg_rdy[s]) stg_vld_q[s] <= src_vld[s];
      end
    end
  end

  // Advance stage payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStg; s++) begin
      if (stg_rdy[s] && src_vld[s]) begin
        stg_yaw_q[s]   <= src_yaw[s];
        stg_pitch_q[s] <= src_pitch[s];
        stg_crc_q[s]   <= stg_crc_d[s];
      end
    end
  end

  // Serializer control: load a frame or step through its bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      ser_cnt_q <= '0;
    end else if (ser_rdy) begin
      ser_vld_q <= stg_vld_q[NumStg-1];
      ser_cnt_q <= '0;
    end else if (frame_o.ready) begin
      ser_cnt_q <= ser_cnt_q + cnt_t'(1);
    end
  end

  // Serializer payload: hold the frame fields while its bytes go out
  always_ff @(posedge clk_i) begin
    if (ser_rdy && stg_vld_q[NumStg-1]) begin
      ser_yaw_q   <= stg_yaw_q[NumStg-1];
      ser_pitch_q <= stg_pitch_q[NumStg-1];
      ser_crc_q   <= stg_crc_q[NumStg-1];
    end
  end

  // Drive the frame channel
  assign frame_o.valid      = ser_vld_q;
  assign frame_o.frame_byte = frame_byte_at(ser_cnt_q, ser_yaw_q, ser_pitch_q, ser_crc_q);
  assign frame_o.frame_last = ser_last;

endmodule

// ===== hw/rtl/acf_checker.sv =====
// Port-level checker for the attitude command framer, with its bind.
`include "attitude_command_framer_crc16_defines.svh"

module acf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       frm_valid_i,
  input logic       frm_ready_i,
  input logic [7:0] frm_byte_i,
  input logic       frm_last_i
);
  import acf_pkg::*;

  cnt_t pos_q;
  logic frm_xfer;

  assign frm_xfer = frm_valid_i && frm_ready_i;

  // Track the send position from transfers alone, wrapping after 14 bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (frm_xfer) begin
      pos_q <= (pos_q == IdxCrcHi) ? '0 : pos_q + cnt_t'(1);
    end
  end

  `ACF_ASSERT_NEXT(a_stall_hold, frm_valid_i && !frm_ready_i, frm_valid_i && $stable(frm_byte_i) && $stable(frm_last_i), "frame byte changed during stall")
  `ACF_ASSERT_NOW(a_last_pos, frm_valid_i, frm_last_i == (pos_q == IdxCrcHi), "frame_last off the 14th byte")
  `ACF_ASSERT_NOW(a_sync_byte, frm_valid_i && (pos_q == '0), frm_byte_i == HdrTab[0], "frame does not open with sync byte")
  `ACF_ASSERT_NOW(a_cmd_byte, frm_valid_i && (pos_q == cnt_t'(HdrBytes - 1)), frm_byte_i == HdrTab[HdrBytes-1], "command byte wrong")

endmodule

bind attitude_command_framer_crc16 acf_checker u_acf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .frm_valid_i (frame_o.valid),
  .frm_ready_i (frame_o.ready),
  .frm_byte_i  (frame_o.frame_byte),
  .frm_last_i  (frame_o.frame_last)
);

// ===== bench/attitude_command_framer_crc16_test.sv =====
// Testbench for the attitude command framer: random and directed angles, frame bytes checked.
module attitude_command_framer_crc16_test;
  import acf_pkg::angle_t;
  import acf_pkg::byte_t;
  import acf_pkg::crc_t;

  // Frame layout as sent on the wire
  localparam int    FrameLen    = 14;
  localparam int    CrcSpan     = 12;
  localparam crc_t  XmodemPoly  = 16'h1021;
  localparam byte_t SyncFirst   = 8'h55;
  localparam byte_t SyncSecond  = 8'h66;
  localparam byte_t CtrlByte    = 8'h01;
  localparam byte_t LenLow      = 8'h04;
  localparam byte_t LenHigh     = 8'h00;
  localparam byte_t SeqByte     = 8'h00;
  localparam byte_t CmdAttitude = 8'h0E;

  localparam int IdlePct       = 29;
  localparam int MaxReported   = 10;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 40;

  typedef struct packed {
    byte_t data;
    logic  last;
  } frame_beat_t;

  logic clk_i;
  logic rst_ni;
  bit   idle_en;
  int   error_count;
  int   quiet_cycles;

  frame_beat_t frame_due[$];

  acf_cmd_if   cmd_if();
  acf_frame_if frame_if();

  attitude_command_framer_crc16 u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .frame_o(frame_if)
  );

  // Free-running clock, period 10
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Build the frame for one command and queue its bytes in send order
  function automatic void queue_frame(angle_t yaw, angle_t pitch);
    byte_t       frame [FrameLen];
    crc_t        crc;
    logic        feedback;
    frame_beat_t beat;
    frame[0]  = SyncFirst;
    frame[1]  = SyncSecond;
    frame[2]  = CtrlByte;
    frame[3]  = LenLow;
    frame[4]  = LenHigh;
    frame[5]  = SeqByte;
    frame[6]  = SeqByte;
    frame[7]  = CmdAttitude;
    frame[8]  = yaw[7:0];
    frame[9]  = yaw[15:8];
    frame[10] = pitch[7:0];
    frame[11] = pitch[15:8];
    // Shift the message through the CRC register one bit at a time, MSB first
    crc = '0;
    for (int i = 0; i < CrcSpan; i++) begin
      for (int b = 7; b >= 0; b--) begin
        feedback = crc[15] ^ frame[i][b];
        crc = {crc[14:0], 1'b0} ^ (feedback ? XmodemPoly : 16'h0000);
      end
    end
    frame[12] = crc[7:0];
    frame[13] = crc[15:8];
    for (int k = 0; k < FrameLen; k++) begin
      beat.data = frame[k];
      beat.last = (k == FrameLen - 1);
      frame_due.push_back(beat);
    end
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MaxReported) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // Random angle: mostly full range, some near zero, near the wrap, or in a plausible span
  function automatic angle_t pick_angle();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return angle_t'(16'($urandom_range(7)) - 16'd4);
    if (pick == 1) return angle_t'(16'h7FFC + 16'($urandom_range(7)));
    if (pick == 2) return angle_t'($urandom_range(3600) - 1800);
    return angle_t'($urandom());
  endfunction

  // Send one command; valid stays high afterwards so the next one can follow directly
  task automatic send_cmd(input angle_t yaw, input angle_t pitch);
    while (idle_en && $urandom_range(99) < IdlePct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.yaw_tenths   <= yaw;
    cmd_if.pitch_tenths <= pitch;
    do @(posedge clk_i); while (!cmd_if.ready);
    queue_frame(yaw, pitch);
  endtask

  // Drop valid and hold until every queued frame byte has been checked
  task automatic wait_frames_done();
    cmd_if.valid <= 1'b0;
    while (frame_due.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, sign boundaries and byte-order patterns
  task automatic test_field_extremes();
    send_cmd(16'sh0000, 16'sh0000);
    send_cmd(16'sh7FFF, 16'sh8000);
    send_cmd(16'sh8000, 16'sh7FFF);
    send_cmd(16'shFFFF, 16'shFFFF);
    send_cmd(16'sh0001, 16'shFFFF);
    send_cmd(16'sh00FF, 16'shFF00);
    send_cmd(16'shFF00, 16'sh00FF);
    send_cmd(16'sh5555, 16'shAAAA);
    send_cmd(16'shAAAA, 16'sh5555);
    send_cmd(16'sh0708, 16'shF8F9);
    send_cmd(16'sh0E10, -16'sh0E10);
    send_cmd(16'sh1234, 16'sh8001);
  endtask

  // No idling on either side, then drain completely
  task automatic test_back_to_back();
    idle_en <= 1'b0;
    repeat (40) send_cmd(pick_angle(), pick_angle());
    wait_frames_done();
    idle_en <= 1'b1;
  endtask

  // Random angles with random gaps and stalls, one full drain midway
  task automatic test_random_traffic();
    repeat (160) send_cmd(pick_angle(), pick_angle());
    wait_frames_done();
    repeat (160) send_cmd(pick_angle(), pick_angle());
  endtask

  // Receiver stalls at random while idling is enabled
  always @(posedge clk_i) begin
    frame_if.ready <= idle_en ? ($urandom_range(99) >= IdlePct) : 1'b1;
  end

  // Compare each frame byte transfer against the oldest expected byte
  always @(posedge clk_i) begin : check_frame
    frame_beat_t want;
    if (rst_ni && frame_if.valid && frame_if.ready) begin
      if (frame_due.size() == 0) begin
        note_error($sformatf("unexpected frame byte %02h last %0b",
                             frame_if.frame_byte, frame_if.frame_last));
      end else begin
        want = frame_due.pop_front();
        if (frame_if.frame_byte !== want.data || frame_if.frame_last !== want.last) begin
          note_error($sformatf("frame byte expected %02h last %0b, got %02h last %0b",
                               want.data, want.last, frame_if.frame_byte,
                               frame_if.frame_last));
        end
      end
    end
  end

  // End the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    idle_en             = 1'b1;
    error_count         = 0;
    quiet_cycles        = 0;
    cmd_if.valid        = 1'b0;
    cmd_if.yaw_tenths   = '0;
    cmd_if.pitch_tenths = '0;
    frame_if.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_back_to_back();
    test_random_traffic();

    wait_frames_done();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
